>>> hdl/mmh_pkg.sv
// Shared constants and types for the multiply-mix 256-bit stream hash.
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int BLOCK_W = 256;
  localparam int PROD_W  = 128;

  // Mixing and finishing constants.
  localparam logic [WORD_W-1:0] K0 = 64'hc3a5c85c97cb3127;
  localparam logic [WORD_W-1:0] K1 = 64'hb492b66fbe98f273;

  // Initial chain words, before the seed is XORed in.
  localparam logic [WORD_W-1:0] INIT_WORDS [4] = '{
    64'h9ae16a3b2f90404f,
    64'hc949d7c7509e6557,
    64'hff51afd7ed558ccd,
    64'hc4ceb9fe1a85ec53
  };

  // Padding marker byte and the byte offset where the length goes.
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [4:0] LEN_OFFSET = 5'd24;
  localparam int         FIN_ROT    = 29;

  // Mixes from the block that holds the length on: its own mix and three more.
  localparam logic [2:0] TAIL_MIXES = 3'd4;

  // Handshake between the sequencer and the shared multiplier.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage : mmh_pkg

`default_nettype wire

>>> hdl/mmh_mul64.sv
// Iterative 64x64 -> 128 multiplier built from one shared 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none

module mmh_mul64
  import mmh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [2:0]        step_r;
  logic              active_r;
  logic              pv_r;
  logic [1:0]        psel_r;
  logic [WORD_W-1:0] prod_r;
  logic [PROD_W-1:0] acc_r;

  logic [HALF_W-1:0] a_half;
  logic [HALF_W-1:0] b_half;
  logic [PROD_W-1:0] partial;
  logic              done;

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
  always_comb begin
    a_half = step_r[1] ? a_r[WORD_W-1:HALF_W] : a_r[HALF_W-1:0];
    b_half = step_r[0] ? b_r[WORD_W-1:HALF_W] : b_r[HALF_W-1:0];
  end

  // Align the registered partial product to its weight.
  always_comb begin
    case (psel_r)
      2'd0:    partial = {{(PROD_W-WORD_W){1'b0}}, prod_r};
      2'd3:    partial = {prod_r, {WORD_W{1'b0}}};
      default: partial = {{HALF_W{1'b0}}, prod_r, {HALF_W{1'b0}}};
    endcase
  end

  assign done        = active_r & step_r[2] & ~pv_r;
  assign rsp.done    = done;
  assign rsp.product = acc_r;

  // Control: issue the four partial products, drain the last one, then signal done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pv_r     <= 1'b0;
      step_r   <= '0;
    end else if (req.start) begin
      active_r <= 1'b1;
      pv_r     <= 1'b0;
      step_r   <= '0;
    end else if (active_r) begin
      if (!step_r[2]) begin
        step_r <= step_r + 3'd1;
        pv_r   <= 1'b1;
      end else begin
        pv_r <= 1'b0;
      end
      if (done) begin
        active_r <= 1'b0;
      end
    end
  end

  // Datapath: operand capture, one registered multiply, accumulate.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else begin
      if (active_r && !step_r[2]) begin
        prod_r <= WORD_W'(a_half) * WORD_W'(b_half);
        psel_r <= step_r[1:0];
      end
      if (pv_r) begin
        acc_r <= acc_r + partial;
      end
    end
  end

endmodule : mmh_mul64

`default_nettype wire

>>> hdl/multiply_mix_256bit_stream_hash.sv
// Top level of the multiply-mix 256-bit stream hash.
//
//   Channel   Direction  Payload
//   in_*      slave      data_word, byte_count in tdata; last in tlast
//   out_*     master     hash_word_0..hash_word_3 in tdata
//   cfg_*     write      seed
//
// An item that does not complete a 32-byte block is buffered without a mix. An
// item that completes a block starts a mix: one mix is two 64x64 products,
// each formed by the single shared 32x32 multiplier.
// A last item adds one padding step, four or five mixes and four finishing
// products. The result waits in an output register; the next message may
// start while it waits, but a newer hash stalls until an older one still
// held has been taken. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module multiply_mix_256bit_stream_hash
  import mmh_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input transactions.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,   // data_word[63:0], byte_count[67:64], zero pad
  input  wire logic         in_tlast,
  // Result transactions.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [255:0]      out_tdata,  // hash_word_0 .. hash_word_3, 64 bits each
  // Seed register.
  input  wire logic         cfg_wr_en,
  input  wire logic [63:0]  cfg_wr_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_MIXP = 6'b000100,
    S_MIXQ = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state_r;
  logic [WORD_W-1:0]  seed_r;
  logic [WORD_W-1:0]  chain_r [4];
  logic [BLOCK_W-1:0] buf_r;
  logic [4:0]         buffered_r;
  logic [WORD_W-1:0]  len_r;
  logic               in_msg_r;
  logic               last_r;
  logic               padded_r;
  logic               len_pend_r;
  logic [2:0]         mixes_left_r;
  logic               issued_r;
  logic [PROD_W-1:0]  p_r;
  logic [1:0]         word_idx_r;
  logic [WORD_W-1:0]  hash_r [4];
  logic               out_valid_r;
  logic [255:0]       out_data_r;

  logic               in_accept;
  logic [WORD_W-1:0]  data_word;
  logic [3:0]         byte_count;
  logic [3:0]         cnt_sat;
  logic [WORD_W-1:0]  data_masked;
  logic [4:0]         off;
  logic [BLOCK_W-1:0] base_buf;
  logic [319:0]       ext;
  logic [5:0]         total;
  logic               blk_full;
  logic [WORD_W-1:0]  base_chain [4];
  logic [WORD_W-1:0]  len_sum;
  logic [BLOCK_W-1:0] pad_buf;
  logic [BLOCK_W-1:0] pad_blk;
  logic               pad_short;
  logic [WORD_W-1:0]  fin_word;
  logic [WORD_W-1:0]  len_inject;
  mul_req_t           mreq;
  mul_rsp_t           mrsp;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid & in_tready;
  assign data_word  = in_tdata[63:0];
  assign byte_count = in_tdata[67:64];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Append the valid bytes of an item at the current buffer offset.
  always_comb begin
    cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
    for (int i = 0; i < 8; i++) begin
      data_masked[8*i +: 8] = (4'(i) < cnt_sat) ? data_word[8*i +: 8] : 8'h00;
    end
    off      = in_msg_r ? buffered_r : 5'd0;
    base_buf = in_msg_r ? buf_r : '0;
    ext      = {64'd0, base_buf} | ({256'd0, data_masked} << {off, 3'b000});
    total    = {1'b0, off} + {2'b00, cnt_sat};
    blk_full = total[5];
    len_sum  = (in_msg_r ? len_r : '0) + {60'd0, cnt_sat};
    for (int i = 0; i < 4; i++) begin
      base_chain[i] = in_msg_r ? chain_r[i] : (INIT_WORDS[i] ^ seed_r);
    end
  end

  // Padding block: marker byte at the fill point, length in the top word if it fits.
  always_comb begin
    pad_buf   = buf_r | ({248'd0, PAD_BYTE} << {buffered_r, 3'b000});
    pad_short = (buffered_r < LEN_OFFSET);
    pad_blk   = pad_short ? {len_r, pad_buf[191:0]} : pad_buf;
  end

  // The length word is folded in after the extra block's mix completes.
  assign len_inject = (len_pend_r && mixes_left_r == 3'd1) ? len_r : '0;

  // Finishing rotate of the selected chain word.
  assign fin_word = {chain_r[word_idx_r][WORD_W-FIN_ROT-1:0],
                     chain_r[word_idx_r][WORD_W-1:WORD_W-FIN_ROT]};

  // Multiplier operands by sequencer step.
  always_comb begin
    mreq.start = 1'b0;
    unique case (state_r)
      S_MIXQ: begin
        mreq.a = chain_r[2] ^ K0;
        mreq.b = chain_r[3] ^ K1;
      end
      S_FIN: begin
        mreq.a = fin_word;
        mreq.b = K1;
      end
      default: begin
        mreq.a = chain_r[0] ^ K0;
        mreq.b = chain_r[1] ^ K1;
      end
    endcase
    if ((state_r == S_MIXP || state_r == S_MIXQ || state_r == S_FIN) && !issued_r) begin
      mreq.start = 1'b1;
    end
  end

  mmh_mul64 u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .rsp  (mrsp)
  );

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // Sequencer and chain state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_msg_r     <= 1'b0;
      last_r       <= 1'b0;
      padded_r     <= 1'b0;
      len_pend_r   <= 1'b0;
      mixes_left_r <= '0;
      issued_r     <= 1'b0;
      word_idx_r   <= '0;
      buffered_r   <= '0;
      len_r        <= '0;
    end else begin
      if (mreq.start) begin
        issued_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            in_msg_r   <= 1'b1;
            last_r     <= in_tlast;
            padded_r   <= 1'b0;
            len_pend_r <= 1'b0;
            len_r      <= len_sum;
            if (blk_full) begin
              for (int i = 0; i < 4; i++) begin
                chain_r[i] <= base_chain[i] ^ ext[WORD_W*i +: WORD_W];
              end
              buf_r        <= {192'd0, ext[319:256]};
              buffered_r   <= 5'(total - 6'd32);
              mixes_left_r <= 3'd1;
              state_r      <= S_MIXP;
            end else begin
              for (int i = 0; i < 4; i++) begin
                chain_r[i] <= base_chain[i];
              end
              buf_r      <= ext[BLOCK_W-1:0];
              buffered_r <= total[4:0];
              if (in_tlast) begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < 4; i++) begin
            chain_r[i] <= chain_r[i] ^ pad_blk[WORD_W*i +: WORD_W];
          end
          padded_r <= 1'b1;
          if (pad_short) begin
            mixes_left_r <= TAIL_MIXES;
          end else begin
            mixes_left_r <= 3'd1;
            len_pend_r   <= 1'b1;
          end
          state_r <= S_MIXP;
        end
        S_MIXP: begin
          if (issued_r && mrsp.done) begin
            p_r      <= mrsp.product;
            issued_r <= 1'b0;
            state_r  <= S_MIXQ;
          end
        end
        S_MIXQ: begin
          if (issued_r && mrsp.done) begin
            issued_r   <= 1'b0;
            chain_r[0] <= p_r[WORD_W-1:0];
            chain_r[1] <= mrsp.product[PROD_W-1:WORD_W];
            chain_r[2] <= mrsp.product[WORD_W-1:0];
            chain_r[3] <= p_r[PROD_W-1:WORD_W] ^ len_inject;
            if (mixes_left_r != 3'd1) begin
              mixes_left_r <= mixes_left_r - 3'd1;
              state_r      <= S_MIXP;
            end else if (len_pend_r) begin
              len_pend_r   <= 1'b0;
              mixes_left_r <= TAIL_MIXES;
              state_r      <= S_MIXP;
            end else if (last_r && !padded_r) begin
              state_r <= S_PAD;
            end else if (last_r) begin
              in_msg_r   <= 1'b0;
              word_idx_r <= '0;
              state_r    <= S_FIN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (issued_r && mrsp.done) begin
            issued_r            <= 1'b0;
            hash_r[word_idx_r]  <= mrsp.product[WORD_W-1:0];
            word_idx_r          <= word_idx_r + 2'd1;
            if (word_idx_r == 2'd3) begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the hash is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {hash_r[3], hash_r[2], hash_r[1], hash_r[0]};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // The multiplier only reports completion during a mix or finishing step.
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == S_MIXP || state_r == S_MIXQ || state_r == S_FIN))
    else $error("multiplier done outside a multiply state");

  // An item that fills no block and is not last leaves the block ready.
  a_short_item_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_tlast && !blk_full) |=> in_tready)
    else $error("not ready after a partial-block item");

  // A mix always has at least one round left to run.
  a_mix_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIXP || state_r == S_MIXQ) |-> (mixes_left_r != 3'd0))
    else $error("mix running with no rounds left");

  // A finished hash waits while the previous result is still held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result overwritten while output stalled");
`endif

endmodule : multiply_mix_256bit_stream_hash

`default_nettype wire
